/* hdl/rbd_pkg.sv */
`default_nettype none
package rbd_pkg;

    localparam int CAPACITY = 16;
    localparam int ELEM_W   = 32;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam int KIND_W   = 3;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // width that holds both the request index and the fill count
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH  = 3'd0,
        K_POP   = 3'd1,
        K_PEEK  = 3'd2,
        K_DEQ   = 3'd3,
        K_READ  = 3'd4,
        K_WRITE = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  value;
        logic [INDEX_W-1:0] index;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_resp;

    typedef struct packed {
        logic accept;
        logic load;
    } t_dp_cmd;

endpackage
`default_nettype wire

/* hdl/rbd_ram.sv */
`default_nettype none
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hdl/rbd_ctrl.sv */
`default_nettype none
module rbd_ctrl
    import rbd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output t_dp_cmd   o_cmd,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   ready;

    // take a new beat only once the result register is free or draining
    assign ready = (r_state == S_IDLE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && ready) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        o_in_stall   = !ready;
        unique case (r_state)
            S_IDLE:  o_cmd.accept = i_in_valid && ready;
            S_FETCH: o_cmd.load   = 1'b1;
            default: o_cmd.load   = 1'b0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

/* hdl/rbd_dp.sv */
`default_nettype none
module rbd_dp
    import rbd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    input  wire t_req    i_req,
    output t_resp        o_resp
);

    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     offset;
    logic [AW:0]       sum;
    logic [AW-1:0]     addr;
    logic [AW-1:0]     head_inc;
    logic [CMPW-1:0]   idx_ext, fill_ext;
    t_status           status;
    logic              wr_hit, rd_hit;
    logic [ELEM_W-1:0] wdata, rdata;

    logic              r_rd_hit;
    t_status           r_status;
    logic [CW-1:0]     r_cnt;
    t_resp             r_resp;

    assign idx_ext  = CMPW'(i_req.index);
    assign fill_ext = CMPW'(r_fill);
    assign wdata    = ELEM_W'(i_req.value);
    assign head_inc = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        offset = '0;
        status = ST_OK;
        wr_hit = 1'b0;
        rd_hit = 1'b0;
        n_head = r_head;
        n_fill = r_fill;
        unique case (i_req.kind) inside
            K_PUSH: begin
                offset = AW'(r_fill);
                if (r_fill == CW'(CAPACITY)) begin
                    status = ST_FULL;
                end else begin
                    wr_hit = 1'b1;
                    n_fill = r_fill + 1'b1;
                end
            end
            K_POP, K_PEEK: begin
                offset = AW'(r_fill - 1'b1);
                if (r_fill == '0) begin
                    status = ST_EMPTY;
                end else begin
                    rd_hit = 1'b1;
                    if (i_req.kind == K_POP) begin
                        n_fill = r_fill - 1'b1;
                    end
                end
            end
            K_DEQ: begin
                if (r_fill == '0) begin
                    status = ST_EMPTY;
                end else begin
                    rd_hit = 1'b1;
                    n_head = head_inc;
                    n_fill = r_fill - 1'b1;
                end
            end
            K_READ, K_WRITE: begin
                offset = AW'(i_req.index);
                if (idx_ext >= fill_ext) begin
                    status = ST_RANGE;
                end else if (i_req.kind == K_READ) begin
                    rd_hit = 1'b1;
                end else begin
                    wr_hit = 1'b1;
                end
            end
            default: status = ST_OK;
        endcase
    end

    // wrap head plus offset around the ring; the sum stays below twice the depth
    assign sum  = {1'b0, r_head} + {1'b0, offset};
    assign addr = (sum >= (AW + 1)'(CAPACITY)) ? AW'(sum - (AW + 1)'(CAPACITY)) : AW'(sum);

    rbd_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && wr_hit),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_cmd.accept) begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_hit <= rd_hit;
            r_status <= status;
            r_cnt    <= n_fill;
        end
        if (i_cmd.load) begin
            r_resp.data   <= r_rd_hit ? DATA_W'(rdata) : '0;
            r_resp.status <= r_status;
            r_resp.count  <= COUNT_W'(r_cnt);
        end
    end

    assign o_resp = r_resp;

endmodule
`default_nettype wire

/* hdl/ring_buffer_deque.sv */
`default_nettype none
// Fixed-capacity deque on a ring of CAPACITY entries: push/pop/peek at the back,
// dequeue at the front, read or write the nth element from the front. Each
// request beat gives exactly one result beat carrying data, status and the new
// count. The accept edge updates head and fill and issues the single RAM access,
// the next edge loads the registered read data into the result register. A new
// request is not taken until the previous one has loaded its result, as the
// storage RAM has a registered read port; a new request is taken while the
// previous result is being drained. No clearing pass after reset.
module ring_buffer_deque
    import rbd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_resp     o_out_data
);

    t_dp_cmd cmd;

    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

    rbd_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_data),
        .o_resp  (o_out_data)
    );

endmodule
`default_nettype wire

/* hdl/rbd_chk.sv */
`default_nettype none
module rbd_chk
    import rbd_pkg::*;
(
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_in_valid,
    input wire logic  o_in_stall,
    input wire t_req  i_in_data,
    input wire logic  o_out_valid,
    input wire logic  i_out_stall,
    input wire t_resp o_out_data
);

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_in_stall)
        else $error("second request taken while busy");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |-> ##2 o_out_valid)
        else $error("no result two cycles after request");

    // a failed request returns zero data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> (o_out_data.data == '0))
        else $error("failed request returned data");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.count <= COUNT_W'(CAPACITY)))
        else $error("count above capacity");

endmodule

bind ring_buffer_deque rbd_chk u_rbd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

/* sim/ring_buffer_deque_checker.sv */
`timescale 1ns / 1ps
module ring_buffer_deque_checker
    import rbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_stall,
    input  t_req  i_in_data,
    input  logic  i_out_valid,
    input  logic  i_out_stall,
    input  t_resp i_out_data,
    output int    o_errors = 0,
    output int    o_pending = 0
);

    logic [ELEM_W-1:0] ring [CAPACITY];
    logic [AW-1:0]     front_pos = '0;
    int                live_cnt = 0;
    int                fault_cnt = 0;
    t_resp             pending_resp [$];
    t_resp             want;
    t_resp             got;

    function automatic t_resp deque_apply(t_req r);
        t_resp res;
        int    off;
        res = '0;
        res.status = ST_OK;
        case (r.kind)
            K_PUSH: begin
                if (live_cnt >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    ring[(int'(front_pos) + live_cnt) % CAPACITY] = r.value[ELEM_W-1:0];
                    live_cnt++;
                end
            end
            K_POP, K_PEEK: begin
                if (live_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = ring[(int'(front_pos) + live_cnt - 1) % CAPACITY];
                    if (r.kind == K_POP) live_cnt--;
                end
            end
            K_DEQ: begin
                if (live_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = ring[front_pos];
                    front_pos = AW'((int'(front_pos) + 1) % CAPACITY);
                    live_cnt--;
                end
            end
            K_READ, K_WRITE: begin
                off = int'(r.index);
                if (off >= live_cnt) begin
                    res.status = ST_RANGE;
                end else if (r.kind == K_READ) begin
                    res.data = ring[(int'(front_pos) + off) % CAPACITY];
                end else begin
                    ring[(int'(front_pos) + off) % CAPACITY] = r.value[ELEM_W-1:0];
                end
            end
            // spare kinds leave the deque untouched
            default: ;
        endcase
        res.count = live_cnt[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_pos = '0;
            live_cnt  = 0;
            pending_resp.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                pending_resp.push_back(deque_apply(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (pending_resp.size() == 0) begin
                    $error("result beat with no request outstanding: data %h status %0d count %0d",
                           got.data, got.status, got.count);
                    fault_cnt++;
                end else begin
                    want = pending_resp.pop_front();
                    if (got.data !== want.data) begin
                        $error("data: expected %h, got %h", want.data, got.data);
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                    end
                    if (got !== want) fault_cnt++;
                end
            end
            o_pending <= pending_resp.size();
        end
        o_errors <= fault_cnt;
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import rbd_pkg::*;

    localparam int LIMIT      = 200000;
    localparam int RAND_ITEMS = 2000;
    localparam int DRAIN      = 6;
    localparam int PAUSE_AT   = 1000;

    localparam logic [KIND_W-1:0] K_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE7 = 3'd7;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_req  i_in_data   = '0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_resp o_out_data;

    int errors;
    int outstanding;
    int cycle_cnt = 0;
    bit calm = 1'b0;

    ring_buffer_deque dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    ring_buffer_deque_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_errors    (errors),
        .o_pending   (outstanding)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 18);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("ring_buffer_deque verification failed");
            $finish;
        end
    end

    task automatic send_req(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                            input logic [INDEX_W-1:0] index);
        t_req r;
        r.kind  = kind;
        r.value = value;
        r.index = index;
        while (!calm && $urandom_range(0, 99) < 18) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        // hold the beat until the block takes it
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        int                  done;
        int                  n;
        int                  roll;
        bit                  grow;
        logic [KIND_W-1:0]   kind;
        logic [DATA_W-1:0]   value;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty deque, one spare kind
        send_req(K_POP,    32'h1234_5678, 4'd0);
        send_req(K_PEEK,   32'h0,         4'd0);
        send_req(K_DEQ,    32'hffff_ffff, 4'd15);
        send_req(K_READ,   32'h0,         4'd0);
        send_req(K_WRITE,  32'hffff_ffff, 4'd15);
        send_req(K_SPARE6, 32'hffff_ffff, 4'd15);
        // fill to capacity, then one more push
        send_req(K_PUSH, 32'h0000_0000, 4'd0);
        send_req(K_PUSH, 32'hffff_ffff, 4'd15);
        for (int i = 2; i < CAPACITY; i++) begin
            send_req(K_PUSH, (i % 2) ? 32'ha5a5_a5a5 : 32'h5a5a_5a5a, 4'(i));
        end
        send_req(K_PUSH,   32'hdead_beef, 4'd0);
        send_req(K_READ,   32'h0,         4'd15);
        send_req(K_WRITE,  32'hffff_ffff, 4'd0);
        send_req(K_SPARE7, 32'h0,         4'd0);
        send_req(K_PEEK,   32'h0,         4'd0);
        send_req(K_POP,    32'h0,         4'd0);
        send_req(K_DEQ,    32'h0,         4'd0);
        send_req(K_READ,   32'h0,         4'd15);

        done = 0;
        n    = 0;
        while (done < RAND_ITEMS) begin
            grow = ((n / 64) % 2) == 0;
            calm <= (done >= 1200 && done < 1500);
            if (n == PAUSE_AT) wait_idle();
            roll = $urandom_range(0, 99);
            if (grow) begin
                kind = (roll < 45) ? K_PUSH  : (roll < 53) ? K_POP  : (roll < 61) ? K_PEEK :
                       (roll < 69) ? K_DEQ   : (roll < 83) ? K_READ : (roll < 97) ? K_WRITE :
                       (roll < 99) ? K_SPARE6 : K_SPARE7;
            end else begin
                kind = (roll < 15) ? K_PUSH  : (roll < 40) ? K_POP  : (roll < 48) ? K_PEEK :
                       (roll < 73) ? K_DEQ   : (roll < 85) ? K_READ : (roll < 97) ? K_WRITE :
                       (roll < 99) ? K_SPARE6 : K_SPARE7;
            end
            roll  = $urandom_range(0, 19);
            value = (roll == 0) ? '0 : (roll == 1) ? '1 : DATA_W'($urandom);
            send_req(kind, value, INDEX_W'($urandom_range(0, 15)));
            if (kind <= K_WRITE) done++;
            n++;
        end

        wait_idle();
        repeat (DRAIN) @(posedge i_clk);
        @(negedge i_clk);
        if (errors == 0) begin
            $display("ring_buffer_deque verification clean");
        end else begin
            $display("ring_buffer_deque verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/rbd_pkg.sv
hdl/rbd_ram.sv
hdl/rbd_ctrl.sv
hdl/rbd_dp.sv
hdl/ring_buffer_deque.sv
hdl/rbd_chk.sv
sim/ring_buffer_deque_checker.sv
sim/tb_top.sv
